### rtl/core/wps_pkg.sv
// wps_pkg: shared types, constants and the arctangent table of the waypoint sequencer
// used by wps_cordic, waypoint_sequencer and wps_checker; depends on nothing else
`timescale 1ns / 1ps

package wps_pkg;

    // defaults for the top-level parameters
    localparam int unsigned MAX_WAYPOINTS_DEF = 256;
    localparam int unsigned CORDIC_STEPS_DEF  = 14;

    // cordic formats: angle with 2^31 equal to pi, vector with 16 fraction bits added
    localparam int unsigned ATAN_ENTRIES = 20;
    localparam int unsigned ATAN_IDX_W   = 5;
    localparam int unsigned ANGLE_W      = 32;
    localparam int unsigned CORDIC_W     = 36;
    localparam int unsigned QUAT_W       = 16;
    localparam int unsigned QUAT_SHIFT   = 16;

    localparam logic [ANGLE_W-1:0] ANGLE_PI   = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] YAW_ROUND  = 32'h0000_4000;

    // configuration registers
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 31;
    localparam int unsigned POS_THR_W  = 31;
    localparam int unsigned HEAD_THR_W = 15;
    localparam int unsigned WP_COUNT_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYPOINT_COUNT     = 2'd2;

    localparam logic [POS_THR_W-1:0]  POS_THR_RESET  = 31'd65536;
    localparam logic [HEAD_THR_W-1:0] HEAD_THR_RESET = 15'd1820;
    localparam logic [WP_COUNT_W-1:0] WP_COUNT_RESET = 9'd1;

    // input item
    typedef struct packed {
        logic               mode;
        logic [7:0]         entry_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] heading;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } req_t;

    // result item
    typedef struct packed {
        logic signed [31:0] cmd_x;
        logic signed [31:0] cmd_y;
        logic signed [31:0] cmd_z;
        logic signed [15:0] cmd_heading;
        logic [7:0]         cmd_index;
        logic               advanced;
    } rsp_t;

    // one waypoint table entry
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [15:0] heading;
    } wp_entry_t;

    // cordic unit status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } cordic_status_t;

    // atan(2^-i) with 2^31 equal to pi
    function automatic logic [ANGLE_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
        logic [ANGLE_W-1:0] a;
        unique case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### rtl/core/wps_cordic.sv
// wps_cordic: iterative vectoring cordic, one micro-rotation per cycle on a shared shifter
// gives atan2(quat_z, quat_w) with 2^31 equal to pi; depends on wps_pkg
`timescale 1ns / 1ps

module wps_cordic #(
    parameter int unsigned CORDIC_STEPS = wps_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [wps_pkg::QUAT_W-1:0] quat_z,
    input  logic signed [wps_pkg::QUAT_W-1:0] quat_w,
    output wps_pkg::cordic_status_t           status,
    output logic [wps_pkg::ANGLE_W-1:0]       angle
);

    localparam int unsigned STEPS = (CORDIC_STEPS < wps_pkg::ATAN_ENTRIES) ?
                                    CORDIC_STEPS : wps_pkg::ATAN_ENTRIES;
    localparam int unsigned CNT_W = $clog2(STEPS);
    localparam int unsigned EXT_W = wps_pkg::CORDIC_W - wps_pkg::QUAT_W - wps_pkg::QUAT_SHIFT;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    logic signed [wps_pkg::CORDIC_W-1:0] x_reg, x_next;
    logic signed [wps_pkg::CORDIC_W-1:0] y_reg, y_next;
    logic [wps_pkg::ANGLE_W-1:0]         ang_reg, ang_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic                                zero_reg, zero_next;
    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;

    logic signed [wps_pkg::CORDIC_W-1:0] x_init, y_init;
    logic signed [wps_pkg::CORDIC_W-1:0] x_shift, y_shift;
    logic [wps_pkg::ANGLE_W-1:0]         atan_val;
    logic                                y_pos;

    // inputs scaled by 2^16, sign extended
    assign x_init = {{EXT_W{quat_w[wps_pkg::QUAT_W-1]}}, quat_w, {wps_pkg::QUAT_SHIFT{1'b0}}};
    assign y_init = {{EXT_W{quat_z[wps_pkg::QUAT_W-1]}}, quat_z, {wps_pkg::QUAT_SHIFT{1'b0}}};

    // shared shifter and table lookup for the current step
    assign x_shift  = x_reg >>> cnt_reg;
    assign y_shift  = y_reg >>> cnt_reg;
    assign atan_val = wps_pkg::atan_entry(wps_pkg::ATAN_IDX_W'(cnt_reg));
    assign y_pos    = !y_reg[wps_pkg::CORDIC_W-1] && (y_reg != '0);

    // next state
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        ang_next  = ang_reg;
        cnt_next  = cnt_reg;
        zero_next = zero_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            // start: load the vector, turning it by pi first in the left half plane
            zero_next = (quat_z == '0) && (quat_w == '0);
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
            if (quat_w[wps_pkg::QUAT_W-1])
            begin
                x_next   = -x_init;
                y_next   = -y_init;
                ang_next = wps_pkg::ANGLE_PI;
            end
            else
            begin
                x_next   = x_init;
                y_next   = y_init;
                ang_next = '0;
            end
        end
        else if (busy_reg)
        begin
            // one micro-rotation toward the x axis
            if (y_pos)
            begin
                x_next   = x_reg + y_shift;
                y_next   = y_reg - x_shift;
                ang_next = ang_reg + atan_val;
            end
            else
            begin
                x_next   = x_reg - y_shift;
                y_next   = y_reg + x_shift;
                ang_next = ang_reg - atan_val;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        ang_reg  <= ang_next;
        zero_reg <= zero_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign angle       = zero_reg ? '0 : ang_reg;

endmodule

### rtl/core/waypoint_sequencer.sv
// waypoint_sequencer: top level, waypoint table, distance unit and index sequencer
// depends on wps_pkg and wps_cordic
`timescale 1ns / 1ps

// Usage
//   request channel: an item is taken at a clock edge with start high and busy low.
//   A load item (mode 0) writes one table slot at that edge and produces no result;
//   busy stays low, so loads may follow every cycle.
//   A pose item (mode 1) raises busy while the distance steps, the cordic and the
//   table fetch run, and its result appears on result with done high for
//   exactly one cycle as busy falls; a new pose is taken once busy is low again.
//   The cordic loop sets the busy time, one micro-rotation per cycle on one shifter;
//   the 32x32 multiplier squares the three axis differences and the threshold in
//   its shadow, then one table read fetches the commanded waypoint.
//   The receiver cannot hold results off: a result is valid only in the done cycle.
//   Configuration: cfg_index / cfg_data written when cfg_valid is high; cfg_ready
//   is always high. Write only while no pose is in flight.
//   Reset: current index 0, thresholds 65536 and 1820, waypoint count 1.
//   The table is not cleared; a pose must not read a slot never loaded.

module waypoint_sequencer #(
    parameter int unsigned MAX_WAYPOINTS = wps_pkg::MAX_WAYPOINTS_DEF,
    parameter int unsigned CORDIC_STEPS  = wps_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  wps_pkg::req_t                        request,
    output logic                                 done,
    output wps_pkg::rsp_t                        result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wps_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int unsigned IDX_W = $clog2(MAX_WAYPOINTS);
    localparam int unsigned CW    = (IDX_W + 1 > wps_pkg::WP_COUNT_W) ?
                                    IDX_W + 1 : wps_pkg::WP_COUNT_W;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_WAYPOINTS);

    // distance phase step codes
    localparam logic [2:0] DIST_X    = 3'd0;
    localparam logic [2:0] DIST_Y    = 3'd1;
    localparam logic [2:0] DIST_Z    = 3'd2;
    localparam logic [2:0] DIST_THR  = 3'd3;
    localparam logic [2:0] DIST_LAST = 3'd4;

    typedef enum logic [1:0] {S_IDLE, S_DIST, S_WAIT, S_FETCH} state_t;

    state_t                            state_reg, state_next;
    logic [2:0]                        cnt_reg, cnt_next;
    logic [IDX_W-1:0]                  cur_idx_reg, cur_idx_next;
    logic                              done_reg, done_next;
    logic                              adv_reg, adv_next;

    logic [wps_pkg::POS_THR_W-1:0]     pos_thr_reg;
    logic [wps_pkg::HEAD_THR_W-1:0]    head_thr_reg;
    logic [wps_pkg::WP_COUNT_W-1:0]    wp_count_reg;

    logic signed [31:0]                px_reg, py_reg, pz_reg;
    logic [63:0]                       prod_reg;
    logic                              prod_sat_reg;
    logic [63:0]                       acc_reg, acc_next;
    logic [63:0]                       thr2_reg;
    wps_pkg::rsp_t                     rsp_reg;

    wps_pkg::wp_entry_t                mem [MAX_WAYPOINTS];
    wps_pkg::wp_entry_t                rd_data_reg;
    logic                              rd_en;
    logic [IDX_W-1:0]                  rd_addr;

    wps_pkg::cordic_status_t           cordic_status;
    logic [wps_pkg::ANGLE_W-1:0]       cordic_angle;

    logic                              pose_accept, load_accept, decide;
    logic [CW-1:0]                     count_eff, wc_ext, cur_ext, inc_ext;
    logic [IDX_W-1:0]                  idx_eff, idx_new;

    logic signed [31:0]                op_pos, op_wp;
    logic [32:0]                       diff, absd;
    logic                              axis_step;
    logic [31:0]                       mul_a;
    logic                              mul_sat;
    logic [63:0]                       term;
    logic [64:0]                       sum;

    logic [wps_pkg::ANGLE_W-1:0]       yaw_sum;
    logic [15:0]                       yaw, herr;
    logic [16:0]                       mag;
    logic                              hit;

    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign pose_accept = start && !busy && request.mode;
    assign load_accept = start && !busy && !request.mode;
    assign decide      = (state_reg == S_WAIT) && cordic_status.done;

    // count in effect and index bounds
    assign wc_ext    = CW'(wp_count_reg);
    assign count_eff = (wc_ext == '0) ? CW'(1) : ((wc_ext > MAX_COUNT) ? MAX_COUNT : wc_ext);
    assign cur_ext   = CW'(cur_idx_reg);
    assign idx_eff   = (cur_ext >= count_eff) ? '0 : cur_idx_reg;
    assign inc_ext   = cur_ext + CW'(1);
    assign idx_new   = hit ? ((inc_ext >= count_eff) ? '0 : inc_ext[IDX_W-1:0]) : cur_idx_reg;

    // yaw angle
    wps_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (pose_accept),
        .quat_z (request.quat_z),
        .quat_w (request.quat_w),
        .status (cordic_status),
        .angle  (cordic_angle)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        op_pos = px_reg;
        op_wp  = rd_data_reg.x;
        unique case (cnt_reg)
            DIST_X:
            begin
                op_pos = px_reg;
                op_wp  = rd_data_reg.x;
            end
            DIST_Y:
            begin
                op_pos = py_reg;
                op_wp  = rd_data_reg.y;
            end
            DIST_Z:
            begin
                op_pos = pz_reg;
                op_wp  = rd_data_reg.z;
            end
            default:
            begin
                op_pos = px_reg;
                op_wp  = rd_data_reg.x;
            end
        endcase
    end

    // absolute axis difference, saturating square beyond 32 bits
    assign diff      = {op_pos[31], op_pos} - {op_wp[31], op_wp};
    assign absd      = diff[32] ? (33'd0 - diff) : diff;
    assign axis_step = (cnt_reg == DIST_X) || (cnt_reg == DIST_Y) || (cnt_reg == DIST_Z);
    assign mul_a     = axis_step ? absd[31:0] : {1'b0, pos_thr_reg};
    assign mul_sat   = axis_step && absd[32];

    // saturating accumulate of the previous product
    assign term = prod_sat_reg ? '1 : prod_reg;
    assign sum  = {1'b0, acc_reg} + {1'b0, term};

    // heading error against the current waypoint
    assign yaw_sum = cordic_angle + wps_pkg::YAW_ROUND;
    assign yaw     = yaw_sum[30:15];
    assign herr    = yaw - rd_data_reg.heading;
    assign mag     = herr[15] ? (17'd0 - {1'b1, herr}) : {1'b0, herr};
    assign hit     = (acc_reg < thr2_reg) && (mag < {2'b00, head_thr_reg});

    // table read port
    always_comb
    begin
        rd_en   = pose_accept || decide;
        rd_addr = decide ? idx_new : idx_eff;
    end

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cur_idx_next = cur_idx_reg;
        done_next    = 1'b0;
        adv_next     = adv_reg;
        acc_next     = acc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pose_accept)
                begin
                    state_next   = S_DIST;
                    cnt_next     = '0;
                    cur_idx_next = idx_eff;
                    acc_next     = '0;
                end
            end
            S_DIST:
            begin
                if ((cnt_reg != DIST_X) && (cnt_reg != DIST_LAST))
                begin
                    acc_next = sum[64] ? '1 : sum[63:0];
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == DIST_LAST)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (cordic_status.done)
                begin
                    cur_idx_next = idx_new;
                    adv_next     = hit;
                    state_next   = S_FETCH;
                end
            end
            S_FETCH:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            cur_idx_reg <= '0;
            done_reg    <= 1'b0;
            adv_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cur_idx_reg <= cur_idx_next;
            done_reg    <= done_next;
            adv_reg     <= adv_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_thr_reg  <= wps_pkg::POS_THR_RESET;
            head_thr_reg <= wps_pkg::HEAD_THR_RESET;
            wp_count_reg <= wps_pkg::WP_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                wps_pkg::CFG_POSITION_THRESHOLD: pos_thr_reg  <= cfg_data;
                wps_pkg::CFG_HEADING_THRESHOLD:  head_thr_reg <= cfg_data[wps_pkg::HEAD_THR_W-1:0];
                wps_pkg::CFG_WAYPOINT_COUNT:     wp_count_reg <= cfg_data[wps_pkg::WP_COUNT_W-1:0];
                default:                         ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pose_accept)
        begin
            px_reg <= request.pos_x;
            py_reg <= request.pos_y;
            pz_reg <= request.pos_z;
        end
        if (state_reg == S_DIST)
        begin
            prod_reg     <= {32'd0, mul_a} * {32'd0, mul_a};
            prod_sat_reg <= mul_sat;
            if (cnt_reg == DIST_LAST)
            begin
                thr2_reg <= prod_reg;
            end
        end
        acc_reg <= acc_next;
        if (state_reg == S_FETCH)
        begin
            rsp_reg.cmd_x       <= rd_data_reg.x;
            rsp_reg.cmd_y       <= rd_data_reg.y;
            rsp_reg.cmd_z       <= rd_data_reg.z;
            rsp_reg.cmd_heading <= rd_data_reg.heading;
            rsp_reg.cmd_index   <= 8'(cur_idx_reg);
            rsp_reg.advanced    <= adv_reg;
        end
    end

    // waypoint table, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (load_accept && (CW'(request.entry_index) < MAX_COUNT))
        begin
            mem[IDX_W'(request.entry_index)] <= '{x:       request.pos_x,
                                                  y:       request.pos_y,
                                                  z:       request.pos_z,
                                                  heading: request.heading};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

### rtl/core/wps_checker.sv
// wps_checker: port-level assertions for waypoint_sequencer, attached by bind
// depends on wps_pkg and the waypoint_sequencer ports
`timescale 1ns / 1ps

module wps_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input wps_pkg::req_t request,
    input logic          done
);

    // a pose item makes the block busy
    a_pose_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.mode) |=> busy)
        else $error("pose item did not raise busy");

    // a load item completes at once and produces no result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !request.mode) |=> (!busy && !done))
        else $error("load item raised busy or a result");

    // a result follows the end of a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result without a preceding busy period");

    // one result per pose: done is never held high
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

endmodule

bind waypoint_sequencer wps_checker u_wps_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done)
);
